/* sv/bwlf_pkg.sv */
`timescale 1ns / 1ps

package bwlf_pkg;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_FLUSH = 2'd1,
        OP_TABLE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BORDER = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_TABLE = 1'b1
    } t_kind;

    localparam int DEFAULT_MAX_WIDTH = 256;

    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_W        = 10;
    localparam int LIT_W        = 17;
    localparam int WIN_W        = 9;
    localparam int TBL_IDX_W    = 3;
    localparam int TBL_WORD_W   = 64;
    localparam int TBL_BIT_W    = 6;
    localparam int TBL_WORDS    = 8;
    localparam int BANKS        = 4;
    localparam int BANK_W       = 2;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = 2;
    localparam int Q_CNT_W      = 3;

    localparam int S_TDATA_W    = 72;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 24;
    localparam int M_TUSER_W    = 1;

    // Window row/column order in row_ok and col_ok: [2] top/left, [1] middle, [0] bottom/right
    typedef struct packed {
        t_kind                   kind;
        logic                    v;
        logic                    border;
        logic [BANK_W-1:0]       wr_bank;
        logic [BANK_W-1:0]       qr_bank;
        logic                    col0;
        logic [2:0]              row_ok;
        logic [2:0]              col_ok;
        logic                    emit;
        logic                    frame_end;
        logic                    clr_lit;
        logic [TBL_IDX_W-1:0]    tbl_index;
        logic [TBL_WORD_W-1:0]   tbl_word;
    } t_cmd;

endpackage

/* sv/binary_window_lut_filter.sv */
// Throughput: one item per cycle, with input and output stalls decoupled by a 4-entry queue.
// Path: a result passes the front-end register, the queue, the line store read register and the
// lookup into the output register, after the item that completes its window is accepted.
// Reset: synchronous, active low; clears positions, lit count, lookup table and registers
// (width 1, height 1, border 0). The line store is not cleared.
`timescale 1ns / 1ps

module binary_window_lut_filter #(
    parameter int MAX_WIDTH = bwlf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] pixel_in, [3:1] table_index, [67:4] table_word, [71:68] zero
    input  logic [bwlf_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // [1:0] op
    input  logic [bwlf_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] out_pixel, [17:1] lit_count, [23:18] zero
    output logic [bwlf_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] row_end
    output logic [bwlf_pkg::M_TUSER_W-1:0]    o_m_axis_tuser,
    // frame_end
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bwlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bwlf_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(bwlf_pkg::t_cmd) + 3 * CW;

    logic                        f_valid;
    bwlf_pkg::t_cmd              f_cmd;
    logic [CW-1:0]               f_wr_addr;
    logic [CW-1:0]               f_addr_a;
    logic [CW-1:0]               f_addr_b;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic [QW-1:0]               q_out;
    bwlf_pkg::t_cmd              b_cmd;
    logic [CW-1:0]               b_wr_addr;
    logic [CW-1:0]               b_addr_a;
    logic [CW-1:0]               b_addr_b;
    logic                        out_pixel;
    logic                        out_row_end;
    logic [bwlf_pkg::LIT_W-1:0]  out_lit;

    assign o_cfg_ready = 1'b1;

    bwlf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser[1:0]),
        .i_pixel     (i_s_axis_tdata[0]),
        .i_tbl_index (i_s_axis_tdata[3:1]),
        .i_tbl_word  (i_s_axis_tdata[67:4]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (!q_full),
        .o_cmd       (f_cmd),
        .o_wr_addr   (f_wr_addr),
        .o_addr_a    (f_addr_a),
        .o_addr_b    (f_addr_b)
    );

    bwlf_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_cmd, f_wr_addr, f_addr_a, f_addr_b}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_cmd, b_wr_addr, b_addr_a, b_addr_b} = q_out;

    bwlf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_cmd       (b_cmd),
        .i_wr_addr   (b_wr_addr),
        .i_addr_a    (b_addr_a),
        .i_addr_b    (b_addr_b),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_pixel     (out_pixel),
        .o_row_end   (out_row_end),
        .o_frame_end (o_m_axis_tlast),
        .o_lit       (out_lit)
    );

    assign o_m_axis_tdata = {{(bwlf_pkg::M_TDATA_W - bwlf_pkg::LIT_W - 1){1'b0}},
                             out_lit, out_pixel};
    assign o_m_axis_tuser = out_row_end;

endmodule

/* sv/bwlf_front.sv */
`timescale 1ns / 1ps

module bwlf_front #(
    parameter int MAX_WIDTH = bwlf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_op,
    input  logic                              i_pixel,
    input  logic [bwlf_pkg::TBL_IDX_W-1:0]    i_tbl_index,
    input  logic [bwlf_pkg::TBL_WORD_W-1:0]   i_tbl_word,
    input  logic                              i_cfg_valid,
    input  logic [bwlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bwlf_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_cmd_valid,
    input  logic                              i_cmd_ready,
    output bwlf_pkg::t_cmd                    o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_wr_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_addr_a,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_addr_b
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = bwlf_pkg::ROW_W;

    logic [bwlf_pkg::CFG_W-1:0] r_frame_width;
    logic [bwlf_pkg::CFG_W-1:0] r_frame_height;
    logic                       r_border;
    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;
    logic                       r_cmd_valid;
    bwlf_pkg::t_cmd             r_cmd;
    logic [CW-1:0]              r_wr_addr;
    logic [CW-1:0]              r_addr_a;
    logic [CW-1:0]              r_addr_b;

    bwlf_pkg::t_cmd             n_cmd;
    logic [CW-1:0]              n_col;
    logic [RW-1:0]              n_row;
    logic [CW-1:0]              n_wr_addr;
    logic [CW-1:0]              n_addr_a;
    logic [CW-1:0]              n_addr_b;

    logic                       accept;
    logic                       pos_item;
    logic [WW-1:0]              w_eff;
    logic [bwlf_pkg::CFG_W-1:0] h_eff;
    logic [CW:0]                w_ext;
    logic [RW-1:0]              h_row;
    logic                       wrap_in;
    logic [RW-1:0]              row1;
    logic [CW-1:0]              col1;
    logic                       restart;
    logic [RW-1:0]              cur_r;
    logic [CW-1:0]              cur_c;
    logic [CW:0]                col_inc;
    logic                       is_col0;
    logic                       no_out;
    logic [RW-1:0]              qr;
    logic                       emit;
    logic                       frame_end;
    logic [CW-1:0]              w_m1;
    logic [CW-1:0]              w_m2;

    assign o_ready     = !r_cmd_valid || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign pos_item    = (i_op == bwlf_pkg::OP_PIXEL) || (i_op == bwlf_pkg::OP_FLUSH);
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;
    assign o_wr_addr   = r_wr_addr;
    assign o_addr_a    = r_addr_a;
    assign o_addr_b    = r_addr_b;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? bwlf_pkg::CFG_W'(1) : r_frame_height;
        w_ext = (CW + 1)'(w_eff);
        h_row = RW'(h_eff);

        // A column left past a narrowed row wraps before use
        wrap_in = {1'b0, r_col} >= w_ext;
        row1    = wrap_in ? r_row + RW'(1) : r_row;
        col1    = wrap_in ? '0 : r_col;
        restart = row1 > (h_row + RW'(1));
        cur_r   = restart ? '0 : row1;
        cur_c   = restart ? '0 : col1;

        col_inc = {1'b0, cur_c} + (CW + 1)'(1);
        if (col_inc >= w_ext) begin
            n_col = '0;
            n_row = cur_r + RW'(1);
        end else begin
            n_col = CW'(col_inc);
            n_row = cur_r;
        end

        is_col0   = cur_c == '0;
        no_out    = (cur_r == '0) || ((cur_r == RW'(1)) && is_col0);
        qr        = is_col0 ? cur_r - RW'(2) : cur_r - RW'(1);
        emit      = !no_out && (qr < h_row);
        frame_end = emit && is_col0 && (qr == h_row - RW'(1));
        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end

        w_m1 = CW'(w_eff - WW'(1));
        w_m2 = (w_eff >= WW'(2)) ? CW'(w_eff - WW'(2)) : '0;

        n_wr_addr = cur_c;
        n_addr_a  = is_col0 ? w_m2 : cur_c - CW'(1);
        n_addr_b  = is_col0 ? w_m1 : cur_c;

        n_cmd           = '0;
        n_cmd.kind      = (i_op == bwlf_pkg::OP_TABLE) ? bwlf_pkg::KIND_TABLE
                                                       : bwlf_pkg::KIND_PIXEL;
        n_cmd.v         = (i_op == bwlf_pkg::OP_PIXEL) ? i_pixel : r_border;
        n_cmd.border    = r_border;
        n_cmd.wr_bank   = cur_r[bwlf_pkg::BANK_W-1:0];
        n_cmd.qr_bank   = qr[bwlf_pkg::BANK_W-1:0];
        n_cmd.col0      = is_col0;
        n_cmd.row_ok    = {qr != '0, 1'b1, (qr + RW'(1)) < h_row};
        n_cmd.col_ok    = {is_col0 ? (w_eff >= WW'(2)) : (cur_c >= CW'(2)), 1'b1, !is_col0};
        n_cmd.emit      = emit;
        n_cmd.frame_end = frame_end;
        n_cmd.clr_lit   = restart;
        n_cmd.tbl_index = i_tbl_index;
        n_cmd.tbl_word  = i_tbl_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bwlf_pkg::CFG_W'(1);
            r_frame_height <= bwlf_pkg::CFG_W'(1);
            r_border       <= 1'b0;
            r_col          <= '0;
            r_row          <= '0;
            r_cmd_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bwlf_pkg::REG_WIDTH:  r_frame_width  <= i_cfg_data;
                    bwlf_pkg::REG_HEIGHT: r_frame_height <= i_cfg_data;
                    bwlf_pkg::REG_BORDER: r_border       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept && pos_item) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            // Drop op 3 here; everything else goes to the back end
            if (accept && (i_op != bwlf_pkg::OP_NONE)) begin
                r_cmd_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= n_cmd;
            r_wr_addr <= n_wr_addr;
            r_addr_a  <= n_addr_a;
            r_addr_b  <= n_addr_b;
        end
    end

endmodule

/* sv/bwlf_queue.sv */
`timescale 1ns / 1ps

module bwlf_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0]              r_slot [bwlf_pkg::Q_DEPTH];
    logic [bwlf_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [bwlf_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [bwlf_pkg::Q_CNT_W-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == bwlf_pkg::Q_CNT_W'(bwlf_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + bwlf_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bwlf_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + bwlf_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - bwlf_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/bwlf_back.sv */
`timescale 1ns / 1ps

module bwlf_back #(
    parameter int MAX_WIDTH = bwlf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_pop,
    input  bwlf_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_wr_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_addr_a,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_addr_b,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_pixel,
    output logic                           o_row_end,
    output logic                           o_frame_end,
    output logic [bwlf_pkg::LIT_W-1:0]     o_lit
);

    localparam int BW = bwlf_pkg::BANK_W;

    // One bit per row bank at each column
    logic [bwlf_pkg::BANKS-1:0]      r_line_mem [MAX_WIDTH];
    logic [bwlf_pkg::TBL_WORD_W-1:0] r_tbl [bwlf_pkg::TBL_WORDS];

    logic                            r_s1_valid;
    bwlf_pkg::t_cmd                  r_s1_cmd;
    logic [bwlf_pkg::BANKS-1:0]      r_rd_a;
    logic [bwlf_pkg::BANKS-1:0]      r_rd_b;
    logic [bwlf_pkg::BANKS-1:0]      r_prev_a;
    logic [bwlf_pkg::LIT_W-1:0]      r_lit;
    logic                            r_out_valid;
    logic                            r_out_pixel;
    logic                            r_out_row_end;
    logic                            r_out_frame_end;
    logic [bwlf_pkg::LIT_W-1:0]      r_out_lit;

    logic                            s1_fire;
    logic                            s2_take;
    logic                            s2_pixel;
    logic [bwlf_pkg::WIN_W-1:0]      win;
    logic                            lut_bit;
    logic [bwlf_pkg::LIT_W-1:0]      lit_base;
    logic [bwlf_pkg::LIT_W-1:0]      lit_new;

    assign s2_take  = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_fire  = i_valid && (!r_s1_valid || s2_take);
    assign o_pop    = s1_fire;
    assign s2_pixel = r_s1_cmd.kind == bwlf_pkg::KIND_PIXEL;

    assign o_valid     = r_out_valid;
    assign o_pixel     = r_out_pixel;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;
    assign o_lit       = r_out_lit;

    // Store the item's own pixel and fetch the two window columns it needs
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (i_cmd.kind == bwlf_pkg::KIND_PIXEL) begin
                r_line_mem[i_wr_addr][i_cmd.wr_bank] <= i_cmd.v;
            end
            r_rd_a   <= r_line_mem[i_addr_a];
            r_rd_b   <= r_line_mem[i_addr_b];
            r_s1_cmd <= i_cmd;
        end
    end

    always_comb begin
        logic [BW-1:0]                 bank [3];
        logic [bwlf_pkg::BANKS-1:0]    word [3];
        logic                          raw;
        int                            i;
        int                            j;

        bank[0] = r_s1_cmd.qr_bank - BW'(1);
        bank[1] = r_s1_cmd.qr_bank;
        bank[2] = r_s1_cmd.qr_bank + BW'(1);
        // At the start of a row the window is the end of the row before it
        word[0] = r_s1_cmd.col0 ? r_rd_a : r_prev_a;
        word[1] = r_s1_cmd.col0 ? r_rd_b : r_rd_a;
        word[2] = r_rd_b;
        win = '0;
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                raw = word[j][bank[i]];
                if (i == 2 && j == 2) begin
                    raw = r_s1_cmd.v;
                end
                win[8 - (3 * i + j)] = (r_s1_cmd.row_ok[2 - i] && r_s1_cmd.col_ok[2 - j])
                                       ? raw : r_s1_cmd.border;
            end
        end
        lut_bit  = r_tbl[win[bwlf_pkg::WIN_W-1:bwlf_pkg::TBL_BIT_W]]
                        [win[bwlf_pkg::TBL_BIT_W-1:0]];
        lit_base = r_s1_cmd.clr_lit ? '0 : r_lit;
        lit_new  = lit_base + bwlf_pkg::LIT_W'(lut_bit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lit       <= '0;
            r_tbl       <= '{default: '0};
        end else begin
            if (s1_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s2_take) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_take) begin
                r_out_valid <= s2_pixel && r_s1_cmd.emit;
                if (!s2_pixel) begin
                    r_tbl[r_s1_cmd.tbl_index] <= r_s1_cmd.tbl_word;
                end else if (r_s1_cmd.emit) begin
                    r_lit <= r_s1_cmd.frame_end ? '0 : lit_new;
                end else if (r_s1_cmd.clr_lit) begin
                    r_lit <= '0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take) begin
            if (s2_pixel) begin
                r_prev_a <= r_rd_a;
            end
            r_out_pixel     <= lut_bit;
            r_out_row_end   <= r_s1_cmd.col0;
            r_out_frame_end <= r_s1_cmd.frame_end;
            r_out_lit       <= lit_new;
        end
    end

    a_table_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_take && !s2_pixel) |=> !r_out_valid)
        else $error("table write produced a result");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_frame_end) |-> r_out_row_end)
        else $error("frame end without row end");

    a_lit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_take && s2_pixel && r_s1_cmd.emit && r_s1_cmd.frame_end) |=> (r_lit == '0))
        else $error("lit count not cleared after frame end");

endmodule

/* tb/binary_window_lut_filter_tb.sv */
`timescale 1ns / 1ps

module binary_window_lut_filter_tb;

    localparam int MAXW        = bwlf_pkg::DEFAULT_MAX_WIDTH;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_BUDGET = 1475;

    typedef struct {
        bwlf_pkg::t_op                    op;
        logic                             pixel;
        logic [bwlf_pkg::TBL_IDX_W-1:0]   tbl_index;
        logic [bwlf_pkg::TBL_WORD_W-1:0]  tbl_word;
    } t_filter_item;

    typedef struct {
        logic                             out_pixel;
        logic                             row_end;
        logic                             frame_end;
        logic [bwlf_pkg::LIT_W-1:0]       lit_count;
    } t_filtered_pixel;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [bwlf_pkg::S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [bwlf_pkg::S_TUSER_W-1:0]   i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [bwlf_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [bwlf_pkg::M_TUSER_W-1:0]   o_m_axis_tuser;
    logic                             o_m_axis_tlast;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [bwlf_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [bwlf_pkg::CFG_W-1:0]       i_cfg_data = '0;

    binary_window_lut_filter #(
        .MAX_WIDTH(MAXW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow of the filter state
    logic [bwlf_pkg::TBL_WORD_W-1:0]  lut_words [bwlf_pkg::TBL_WORDS] = '{default: '0};
    logic                             line_bits [bwlf_pkg::BANKS][MAXW];
    logic [bwlf_pkg::CFG_W-1:0]       frame_width_reg = 9'd1;
    logic [bwlf_pkg::CFG_W-1:0]       frame_height_reg = 9'd1;
    logic                             border_reg = 1'b0;
    int                               row_pos = 0;
    int                               col_pos = 0;
    logic [bwlf_pkg::LIT_W-1:0]       lit_total = '0;

    t_filter_item           filter_items[$];
    t_filtered_pixel        expected_pixels[$];
    t_filter_item           offered_item;
    int                     fed_items = 0;
    int                     pixel_errors = 0;
    int                     src_idle_pct = 18;
    int                     snk_idle_pct = 57;
    int                     hold_requests = 0;
    int                     hold_served = 0;
    int                     hold_left = 0;

    function automatic int eff_width(input int v);
        if (v == 0) return 1;
        if (v > MAXW) return MAXW;
        return v;
    endfunction

    function automatic int eff_height(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void predict_filtered_pixel(input t_filter_item it);
        int w, h, r, c, qr, qc, nr, nc;
        logic b, lit;
        logic [bwlf_pkg::WIN_W-1:0] win;
        t_filtered_pixel res;
        if (it.op == bwlf_pkg::OP_TABLE) begin
            lut_words[it.tbl_index] = it.tbl_word;
            return;
        end
        if (it.op == bwlf_pkg::OP_NONE) return;
        w = eff_width(frame_width_reg);
        h = eff_height(frame_height_reg);
        // wrap a column left over from a wider setting, restart a frame that ran past the end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos > h + 1) begin
            row_pos = 0;
            col_pos = 0;
            lit_total = '0;
        end
        r = row_pos;
        c = col_pos;
        line_bits[r & 3][c] = (it.op == bwlf_pkg::OP_PIXEL) ? it.pixel : border_reg;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (r == 0 || (r == 1 && c == 0)) return;
        if (c == 0) begin
            qr = r - 2;
            qc = w - 1;
        end else begin
            qr = r - 1;
            qc = c - 1;
        end
        if (qr >= h) return;
        win = '0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = qr + dr;
                nc = qc + dc;
                b = border_reg;
                if (nr >= 0 && nr < h && nc >= 0 && nc < w) b = line_bits[nr & 3][nc];
                win = {win[bwlf_pkg::WIN_W-2:0], b};
            end
        end
        lit = lut_words[win[8:6]][win[5:0]];
        lit_total = lit_total + bwlf_pkg::LIT_W'(lit);
        res.out_pixel = lit;
        res.row_end = (qc == w - 1);
        res.frame_end = (qc == w - 1) && (qr == h - 1);
        res.lit_count = lit_total;
        expected_pixels.push_back(res);
        if (res.frame_end) begin
            row_pos = 0;
            col_pos = 0;
            lit_total = '0;
        end
    endfunction

    // Items still needed until the frame in progress ends (at row h+1, column 0)
    function automatic int items_to_frame_end(input int r, input int c, input int w, input int h);
        int n;
        n = 0;
        while (1) begin
            n++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r > h + 1) begin
                r = 0;
                c = 0;
            end
            if (r == h + 1 && c == 0) return n;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
        end
        return n;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            pixel_errors++;
        end
    endtask

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always #5 i_clk = ~i_clk;

    // Input side: predict on acceptance, then offer the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) predict_filtered_pixel(offered_item);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (filter_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_item = filter_items.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {4'b0, offered_item.tbl_word, offered_item.tbl_index,
                                       offered_item.pixel};
                    i_s_axis_tuser <= offered_item.op;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_filtered_pixel got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.out_pixel = o_m_axis_tdata[0];
                got.lit_count = o_m_axis_tdata[bwlf_pkg::LIT_W:1];
                got.row_end = o_m_axis_tuser[0];
                got.frame_end = o_m_axis_tlast;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got pixel %0b lit %0d",
                             $time, got.out_pixel, got.lit_count);
                    pixel_errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_pixel", want.out_pixel, got.out_pixel);
                    check_field("row_end", want.row_end, got.row_end);
                    check_field("frame_end", want.frame_end, got.frame_end);
                    check_field("lit_count", want.lit_count, got.lit_count);
                end
            end
            i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_item(input bwlf_pkg::t_op op, input logic pixel, input logic [2:0] index,
                             input logic [63:0] word);
        t_filter_item it;
        it.op = op;
        it.pixel = pixel;
        it.tbl_index = index;
        it.tbl_word = word;
        filter_items.push_back(it);
        if (op != bwlf_pkg::OP_NONE) fed_items++;
    endtask

    task automatic push_random(input bwlf_pkg::t_op op);
        push_item(op, 1'($urandom_range(1)), 3'($urandom_range(7)), {$urandom, $urandom});
    endtask

    // Raster run from linear position k0; table writes and dead items are mixed in
    task automatic push_frame_run(input int n, input int k0, input int w, input int h);
        for (int k = k0; k < k0 + n; k++) begin
            if ($urandom_range(99) < 6) push_random(bwlf_pkg::OP_TABLE);
            if ($urandom_range(99) < 3) push_random(bwlf_pkg::OP_NONE);
            if (k / w < h) push_random(bwlf_pkg::OP_PIXEL);
            else push_random(($urandom_range(3) == 0) ? bwlf_pkg::OP_PIXEL
                                                      : bwlf_pkg::OP_FLUSH);
        end
    endtask

    // Hold until every item is taken and every result is back, then let the pipe drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (filter_items.size() != 0 || i_s_axis_tvalid || expected_pixels.size() != 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input bwlf_pkg::t_cfg_reg idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= bwlf_pkg::CFG_W'(value);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bwlf_pkg::REG_WIDTH:  frame_width_reg = bwlf_pkg::CFG_W'(value);
            bwlf_pkg::REG_HEIGHT: frame_height_reg = bwlf_pkg::CFG_W'(value);
            bwlf_pkg::REG_BORDER: border_reg = value[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h, input int border);
        write_reg(bwlf_pkg::REG_WIDTH, w);
        write_reg(bwlf_pkg::REG_HEIGHT, h);
        write_reg(bwlf_pkg::REG_BORDER, border);
    endtask

    initial begin : stimulus
        int phase, w, h, frames, n, len;
        bit partial;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: 1x1 frame, dark border, empty table
        push_item(bwlf_pkg::OP_TABLE, 1'b0, 3'd0, {64{1'b1}});
        push_item(bwlf_pkg::OP_TABLE, 1'b1, 3'd7, {64{1'b1}});
        push_random(bwlf_pkg::OP_NONE);
        push_item(bwlf_pkg::OP_PIXEL, 1'b1, 3'd7, '0);
        push_random(bwlf_pkg::OP_NONE);
        // pixel past the frame end acts as a flush item
        push_item(bwlf_pkg::OP_PIXEL, 1'b0, 3'd0, '0);
        push_item(bwlf_pkg::OP_FLUSH, 1'b1, 3'd5, 64'hA5A5_5A5A_0F0F_F0F0);
        wait_idle();

        // Lit border, then shrink the width partway through the frame
        set_frame(3, 2, 1);
        push_item(bwlf_pkg::OP_TABLE, 1'b0, 3'd3, 64'hDEAD_BEEF_0123_4567);
        push_frame_run(5, 0, 3, 2);
        wait_idle();
        write_reg(bwlf_pkg::REG_WIDTH, 2);
        push_frame_run(items_to_frame_end(row_pos, col_pos, 2, 2), row_pos * 2 + col_pos, 2, 2);
        push_item(bwlf_pkg::OP_TABLE, 1'b0, 3'd0, '0);
        push_item(bwlf_pkg::OP_TABLE, 1'b0, 3'd7, '0);

        phase = 0;
        while (fed_items < ITEM_BUDGET) begin
            wait_idle();
            if (fed_items < 500) begin
                src_idle_pct = 18;
                snk_idle_pct = 57;
            end else if (fed_items < 1000) begin
                src_idle_pct = 57;
                snk_idle_pct = 18;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            frames = $urandom_range(1, 3);
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            case (phase)
                1: begin w = 24; h = 6; frames = 1; end
                2: begin w = MAXW; h = 1; frames = 1; end
                4: begin w = 1; h = 256; frames = 1; end
                6: begin w = 0; h = 0; frames = 3; end
                default: ;
            endcase
            set_frame(w, h, $urandom_range(1));
            w = eff_width(w);
            h = eff_height(h);
            for (int f = 0; f < frames; f++) begin
                len = (h + 1) * w + 1;
                partial = (w * h <= 160) && ($urandom_range(4) == 0);
                if (partial) begin
                    n = $urandom_range(1, len - 1);
                    push_frame_run(n, 0, w, h);
                    wait_idle();
                    case ($urandom_range(2))
                        0: write_reg(bwlf_pkg::REG_WIDTH, $urandom_range(1, w));
                        1: write_reg(bwlf_pkg::REG_HEIGHT, $urandom_range(1, 10));
                        default: write_reg(bwlf_pkg::REG_BORDER, !border_reg);
                    endcase
                    w = eff_width(frame_width_reg);
                    h = eff_height(frame_height_reg);
                    n = items_to_frame_end(row_pos, col_pos, w, h);
                    push_frame_run(n, row_pos * w + col_pos, w, h);
                end else begin
                    push_frame_run(len, 0, w, h);
                end
            end
            // stall the output while a long frame is queued so the input backs up
            if (phase == 1) hold_requests++;
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (pixel_errors == 0 && expected_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
